// ===== rtl/spq_pkg.sv =====
// Package for the sorted priority queue: operation codes, field widths,
// and the control and flag structs shared by the top level and its cells.
// No dependencies.
package spq_pkg;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned CNT_W  = 5;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_FIND   = 2'd2
  } func_e;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

  // per-cell compare results against the broadcast value
  typedef struct packed {
    logic ge;
    logic gt;
    logic eq;
  } cell_flags_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an entry, compares it with the
// broadcast value and shifts toward head or tail as the request needs.
// Depends on spq_pkg.
module spq_cell (
  input  logic                              clk_i,
  input  spq_pkg::cell_ctrl_t               ctrl_i,
  input  logic                              occ_i,
  input  logic                              left_ge_i,
  input  logic signed [spq_pkg::DATA_W-1:0] left_data_i,
  input  logic signed [spq_pkg::DATA_W-1:0] right_data_i,
  output logic signed [spq_pkg::DATA_W-1:0] data_o,
  output spq_pkg::cell_flags_t              flags_o
);
  import spq_pkg::*;

  logic signed [DATA_W-1:0] data_q, data_d;

  always_comb begin
    flags_o.ge = occ_i && (data_q >= ctrl_i.value);
    flags_o.gt = occ_i && (data_q > ctrl_i.value);
    flags_o.eq = occ_i && (data_q == ctrl_i.value);
  end

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (!left_ge_i) begin
        data_d = left_data_i;
      end else if (!flags_o.ge) begin
        data_d = ctrl_i.value;
      end
    end else if (ctrl_i.rem && !flags_o.gt) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Sorted priority queue top level: a chain of spq_cell slots, request
// decode, first-match encoding, entry count and the result register.
// Depends on spq_pkg and spq_cell.
//
// Usage:
//   Requests enter on in_valid_i/in_stall_o with func_i and value_i; each
//   request gives exactly one result on out_valid_o/out_stall_i carrying
//   ok_o, position_o, count_o, head_value_o and head_valid_o.
//   Entries are kept in descending signed order, head first. Insert puts
//   the value behind all entries greater or equal and fails when full;
//   remove drops the first equal entry; find reports its index.
//   Every cell compares against the request value in parallel and shifts
//   by one slot in the same cycle: the result is registered at the edge
//   that accepts the request, and a new request is taken every cycle while
//   results are drained.
//   When the receiver stalls, the result holds and in_stall_o rises until
//   it is taken; the chain keeps its contents.
//   Reset empties the queue (count zero) and clears the result valid; the
//   cell contents are not cleared and are never read beyond the count.
module sorted_priority_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [spq_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [spq_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic [spq_pkg::POS_W-1:0]         position_o,
  output logic [spq_pkg::CNT_W-1:0]         count_o,
  output logic signed [spq_pkg::DATA_W-1:0] head_value_o,
  output logic                              head_valid_o
);
  import spq_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                     accept;
  logic                     full;
  logic                     found;
  logic                     ok;
  logic [IW-1:0]            pos;
  logic [IW-1:0]            match_pos;
  logic [CW-1:0]            count_q, count_d;
  logic signed [DATA_W-1:0] head_d;
  cell_ctrl_t               ctrl;

  logic signed [DATA_W-1:0] data [DEPTH];
  cell_flags_t              flags [DEPTH];
  logic [DEPTH-1:0]         occ, ge_vec, gt_vec, eq_vec, first_vec;

  logic                     out_valid_q, out_valid_d;
  logic                     ok_q;
  logic [POS_W-1:0]         pos_q;
  logic [CNT_W-1:0]         cnt_q;
  logic signed [DATA_W-1:0] head_q;
  logic                     head_valid_q;

  logic [IW+POS_W-1:0]      pos_ext;
  logic [CW+CNT_W-1:0]      cnt_ext;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(DEPTH));

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     left_ge;
    logic signed [DATA_W-1:0] left_data;
    logic signed [DATA_W-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_ge   = 1'b1;
      assign left_data = value_i;
    end else begin : g_mid
      assign left_ge   = flags[i-1].ge;
      assign left_data = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data = data[i];
    end else begin : g_body
      assign right_data = data[i+1];
    end

    assign occ[i]    = (CW'(i) < count_q);
    assign ge_vec[i] = flags[i].ge;
    assign gt_vec[i] = flags[i].gt;
    assign eq_vec[i] = flags[i].eq;

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occ_i        (occ[i]),
      .left_ge_i    (left_ge),
      .left_data_i  (left_data),
      .right_data_i (right_data),
      .data_o       (data[i]),
      .flags_o      (flags[i])
    );
  end

  assign found     = |eq_vec;
  // entries greater than the value form a prefix; the slot right after it is the first match
  assign first_vec = ~gt_vec & {gt_vec[DEPTH-2:0], 1'b1};

  always_comb begin
    match_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match_pos = match_pos | (first_vec[i] ? IW'(i) : IW'(0));
    end
  end

  always_comb begin
    ctrl.value = value_i;
    ctrl.ins   = 1'b0;
    ctrl.rem   = 1'b0;
    ok         = 1'b0;
    pos        = '0;
    unique case (func_e'(func_i))
      FUNC_INSERT: begin
        ok       = !full;
        ctrl.ins = accept && !full;
      end
      FUNC_REMOVE: begin
        ok       = found;
        ctrl.rem = accept && found;
      end
      FUNC_FIND: begin
        ok  = found;
        pos = found ? match_pos : '0;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    count_d = count_q;
    head_d  = data[0];
    if (ctrl.ins) begin
      count_d = count_q + CW'(1);
      if (!ge_vec[0]) begin
        head_d = value_i;
      end
    end else if (ctrl.rem) begin
      count_d = count_q - CW'(1);
      if (!gt_vec[0]) begin
        head_d = data[1];
      end
    end
    if (count_d == '0) begin
      head_d = '0;
    end
  end

  assign pos_ext = {{POS_W{1'b0}}, pos};
  assign cnt_ext = {{CNT_W{1'b0}}, count_d};

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (accept) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_q         <= ok;
      pos_q        <= pos_ext[POS_W-1:0];
      cnt_q        <= cnt_ext[CNT_W-1:0];
      head_q       <= head_d;
      head_valid_q <= (count_d != '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ok_o         = ok_q;
  assign position_o   = pos_q;
  assign count_o      = cnt_q;
  assign head_value_o = head_q;
  assign head_valid_o = head_valid_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow the count");

  a_remove_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.rem |=> count_q == $past(count_q) - CW'(1))
    else $error("remove did not shrink the count");

  a_no_ins_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !ctrl.ins)
    else $error("insert into a full queue");

  for (genvar i = 0; i < DEPTH - 1; i++) begin : g_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      occ[i+1] |-> data[i] >= data[i+1])
      else $error("entries out of order");
  end
`endif

endmodule

// ===== bench/spq_checker.sv =====
`timescale 1ns / 100ps
// spq_checker: watches the request and result channels of sorted_priority_queue,
// keeps its own sorted copy of the queue and checks every result field in order.
// Depends on spq_pkg.
module spq_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [spq_pkg::FUNC_W-1:0]        func_i,
  input  logic signed [spq_pkg::DATA_W-1:0] value_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic                              ok_i,
  input  logic [spq_pkg::POS_W-1:0]         position_i,
  input  logic [spq_pkg::CNT_W-1:0]         count_i,
  input  logic signed [spq_pkg::DATA_W-1:0] head_value_i,
  input  logic                              head_valid_i,
  output int                                mismatch_o,
  output int                                pending_o,
  output int                                results_o,
  output int                                rejects_o
);
  import spq_pkg::*;

  typedef struct packed {
    logic                     ok;
    logic [POS_W-1:0]         position;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] head_value;
    logic                     head_valid;
  } spq_result_t;

  logic signed [DATA_W-1:0] slots [DEPTH];
  int unsigned fill = 0;
  spq_result_t expected_results [$];
  int mismatches = 0;
  int pending = 0;
  int results = 0;
  int rejects = 0;

  assign mismatch_o = mismatches;
  assign pending_o  = pending;
  assign results_o  = results;
  assign rejects_o  = rejects;

  // apply one request to the sorted copy and return the result it must give
  function automatic spq_result_t predict_queue_op(input logic [FUNC_W-1:0] func,
                                                   input logic signed [DATA_W-1:0] value);
    spq_result_t r;
    int unsigned k;
    bit hit;
    r = '0;
    k = 0;
    hit = 1'b0;
    case (func)
      FUNC_INSERT: begin
        if (fill < DEPTH) begin
          while (k < fill && slots[k] >= value) k++;
          for (int unsigned i = fill; i > k; i--) slots[i] = slots[i-1];
          slots[k] = value;
          fill++;
          r.ok = 1'b1;
        end
      end
      FUNC_REMOVE, FUNC_FIND: begin
        while (k < fill && !hit) begin
          if (slots[k] == value) hit = 1'b1;
          else k++;
        end
        if (hit) begin
          r.ok = 1'b1;
          if (func == FUNC_FIND) begin
            r.position = k[POS_W-1:0];
          end else begin
            for (int unsigned i = k; i + 1 < fill; i++) slots[i] = slots[i+1];
            fill--;
          end
        end
      end
      default: ;
    endcase
    r.count      = fill[CNT_W-1:0];
    r.head_valid = (fill > 0);
    r.head_value = (fill > 0) ? slots[0] : '0;
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    spq_result_t want;
    spq_result_t got;
    if (!rst_ni) begin
      fill = 0;
      expected_results.delete();
      pending = 0;
    end else begin
      // results first: a request accepted at this edge cannot answer at it
      if (out_valid_i && !out_stall_i) begin
        got = {ok_i, position_i, count_i, head_value_i, head_valid_i};
        results++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result ok=%0b pos=%0d count=%0d head=%0d/%0b",
                     $realtime, got.ok, got.position, got.count, got.head_value,
                     got.head_valid);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch: expected ok=%0b pos=%0d count=%0d head=%0d/%0b",
                       $realtime, want.ok, want.position, want.count, want.head_value,
                       want.head_valid);
              $display("%0t: result mismatch: got      ok=%0b pos=%0d count=%0d head=%0d/%0b",
                       $realtime, got.ok, got.position, got.count, got.head_value,
                       got.head_valid);
            end
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = predict_queue_op(func_i, value_i);
        if (func_i == FUNC_INSERT && !want.ok) rejects++;
        expected_results.push_back(want);
      end
      pending = expected_results.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: request stimulus and verdict for sorted_priority_queue, with random
// idle bursts on both channels. Depends on spq_pkg, sorted_priority_queue, spq_checker.
module tb_top;
  import spq_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int          N_ITEMS     = 1350;
  localparam int          QUIET_TAIL  = 150;
  localparam int          CYCLE_LIMIT = 400000;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [FUNC_W-1:0]        func_i      = FUNC_INSERT;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic                     ok_o;
  logic [POS_W-1:0]         position_o;
  logic [CNT_W-1:0]         count_o;
  logic signed [DATA_W-1:0] head_value_o;
  logic                     head_valid_o;

  int mismatches, pending, results, rejects;
  int sent = 0;
  int n_directed = 0;
  int op_count [4] = '{0, 0, 0, 0};
  int cycles = 0;
  bit gaps_on = 1'b1;
  bit stall_on = 1'b1;
  logic signed [DATA_W-1:0] pool [6];

  sorted_priority_queue #(.DEPTH(DEPTH)) dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .value_i,
    .out_valid_o, .out_stall_i, .ok_o, .position_o, .count_o,
    .head_value_o, .head_valid_o
  );

  spq_checker #(.DEPTH(DEPTH)) u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .func_i, .value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .ok_i(ok_o), .position_i(position_o),
    .count_i(count_o), .head_value_i(head_value_o), .head_valid_i(head_valid_o),
    .mismatch_o(mismatches), .pending_o(pending), .results_o(results),
    .rejects_o(rejects)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always begin
    @(negedge clk_i);
    if (rst_ni && stall_on && $urandom_range(0, 4) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic push_request(input logic [FUNC_W-1:0] func,
                              input logic signed [DATA_W-1:0] value);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= func;
    value_i    <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
    op_count[func]++;
  endtask

  task automatic refill_pool();
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 3))
        0:       pool[i] = $urandom();
        1:       pool[i] = $signed($urandom_range(0, 20)) - 10;
        2:       pool[i] = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
        default: pool[i] = $signed($urandom_range(0, 2000)) - 1000;
      endcase
    end
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
      1, 2:    return $urandom();
      default: return pool[$urandom_range(0, 5)];
    endcase
  endfunction

  // mode 0 fills the queue, mode 1 drains it, mode 2 mixes
  function automatic logic [FUNC_W-1:0] pick_func(input int mode);
    int r;
    int ins_pct;
    int rem_pct;
    r = $urandom_range(0, 99);
    ins_pct = (mode == 0) ? 75 : (mode == 1) ? 20 : 40;
    rem_pct = (mode == 0) ? 10 : (mode == 1) ? 55 : 30;
    if (r < ins_pct) return FUNC_INSERT;
    if (r < ins_pct + rem_pct) return FUNC_REMOVE;
    if (r < 97) return FUNC_FIND;
    return FUNC_UNUSED;
  endfunction

  initial begin : stimulus
    int phase_len;
    int mode;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty queue, extremes, duplicates, misses, unused code
    push_request(FUNC_FIND, 0);
    push_request(FUNC_REMOVE, 5);
    push_request(FUNC_UNUSED, 0);
    push_request(FUNC_INSERT, VAL_MAX);
    push_request(FUNC_INSERT, VAL_MIN);
    push_request(FUNC_INSERT, 0);
    push_request(FUNC_INSERT, -1);
    push_request(FUNC_INSERT, 0);
    push_request(FUNC_INSERT, VAL_MAX);
    push_request(FUNC_FIND, 0);
    push_request(FUNC_FIND, VAL_MIN);
    push_request(FUNC_FIND, -1);
    push_request(FUNC_UNUSED, -1);
    push_request(FUNC_REMOVE, VAL_MAX);
    push_request(FUNC_REMOVE, 0);
    push_request(FUNC_FIND, 0);
    push_request(FUNC_REMOVE, 12345);
    push_request(FUNC_INSERT, 1);
    push_request(FUNC_INSERT, 32'sh5555_5555);
    push_request(FUNC_INSERT, 32'shAAAA_AAAA);
    push_request(FUNC_FIND, 32'shAAAA_AAAA);
    n_directed = sent;

    while (sent < N_ITEMS) begin
      refill_pool();
      mode      = $urandom_range(0, 2);
      phase_len = $urandom_range(20, 80);
      gaps_on   = ($urandom_range(0, 3) != 0);
      stall_on  = ($urandom_range(0, 3) != 0);
      for (int j = 0; j < phase_len && sent < N_ITEMS; j++) begin
        if (N_ITEMS - sent <= QUIET_TAIL) begin
          gaps_on  = 1'b0;
          stall_on = 1'b0;
        end
        push_request(pick_func(mode), pick_value());
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    $display("Sent %0d requests (%0d directed): %0d inserts, %0d removes, %0d finds, %0d unused",
             sent, n_directed, op_count[FUNC_INSERT], op_count[FUNC_REMOVE],
             op_count[FUNC_FIND], op_count[FUNC_UNUSED]);
    $display("Checked %0d results, %0d inserts refused on a full queue, %0d mismatches",
             results, rejects, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
